@@ sv/pse_pkg.sv @@
// Shared constants and helper functions for the prime sieve engine.
package pse_pkg;

  // Largest number the flag store can hold.
  localparam int MAX_LIMIT  = 65535;
  localparam int FLAG_BYTES = MAX_LIMIT / 8 + 1;
  localparam int ADDR_W     = (FLAG_BYTES > 1) ? $clog2(FLAG_BYTES) : 1;
  localparam int LIM_W      = $clog2(MAX_LIMIT + 1);
  localparam int CAND_W     = LIM_W + 1;
  localparam int CFG_W      = 16;
  localparam int OUT_W      = 16;
  localparam int BYTE_W     = 8;

  localparam logic [BYTE_W-1:0] FLAGS_ALL = 8'hFF;
  localparam logic [BYTE_W-1:0] FLAG_ONE  = 8'h01;
  localparam logic [CAND_W-1:0] FIRST_CAND = CAND_W'(2);

  // Index of the lowest set bit; zero when the byte is empty.
  function automatic logic [2:0] low_bit(input logic [BYTE_W-1:0] b);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (b[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

  // Keep bits at and above lo.
  function automatic logic [BYTE_W-1:0] lo_mask(input logic [2:0] lo);
    return FLAGS_ALL << lo;
  endfunction

  // Keep bits at and below hi.
  function automatic logic [BYTE_W-1:0] hi_mask(input logic [2:0] hi);
    return FLAGS_ALL >> (3'd7 - hi);
  endfunction

endpackage

@@ sv/pse_flag_ram.sv @@
// Single-port-write, single-port-read flag RAM with registered read data.
module pse_flag_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/prime_sieve_engine_unit.sv @@
// Top level of the prime sieve engine: sequencer around the packed flag RAM.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-------------------------------
//   input   | start, busy, in_restart                 | taken when start && !busy
//   result  | out_valid, out_prime_value, out_found   | one-cycle strobe, no stall
//   config  | cfg_we, cfg_upper_limit                 | written when cfg_we is high
//
// Steps: a plain request first issues the read of the candidate's byte,
// then scans the flag bytes in turn, then clears each multiple of the
// prime found (about limit/p of them for prime p) and ends with a step that
// lands the last write; the single read port of the flag RAM sets the pace
// of both the scan and the clear sweep. The result strobe follows the cycle
// that finds the prime. A restart item first refills the whole flag RAM, one
// byte per cycle, before the search begins.
// Reset (synchronous, rst_n low) runs the same fill; busy stays high and no
// item is taken until it ends. Configuration writes are taken at any time.
// The result strobe lasts exactly one cycle; the receiver cannot stall it.
module prime_sieve_engine_unit
  import pse_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input item
  input  logic             start,
  output logic             busy,
  input  logic             in_restart,
  // result item
  output logic             out_valid,
  output logic [OUT_W-1:0] out_prime_value,
  output logic             out_found,
  // configuration
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_upper_limit
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_PREP,
    ST_CHK,
    ST_CLR
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FLAG_BYTES - 1);

  state_t              state_r, state_nxt;
  logic [CAND_W-1:0]   cand_r, cand_nxt;
  logic [CFG_W-1:0]    upper_limit_r, upper_limit_nxt;
  logic [ADDR_W-1:0]   fill_addr_r, fill_addr_nxt;
  logic                fill_item_r, fill_item_nxt;
  logic [ADDR_W-1:0]   scan_addr_r, scan_addr_nxt;
  logic [2:0]          scan_lo_r, scan_lo_nxt;
  logic [LIM_W-1:0]    prime_r, prime_nxt;
  logic [CAND_W-1:0]   mult_r, mult_nxt;
  // clear pipeline: read issued, modify and write in the next cycle
  logic                clr_v_r, clr_v_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [2:0]          clr_bit_r, clr_bit_nxt;
  // last write, forwarded when the next read hits the same byte
  logic                fwd_v_r, fwd_v_nxt;
  logic [ADDR_W-1:0]   fwd_addr_r, fwd_addr_nxt;
  logic [BYTE_W-1:0]   fwd_data_r, fwd_data_nxt;
  // registered result
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_prime_r, out_prime_nxt;
  logic                out_found_r, out_found_nxt;

  // RAM ports
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_wa;
  logic [BYTE_W-1:0]   ram_wd;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_ra;
  logic [BYTE_W-1:0]   ram_rd;

  // derived values
  logic [31:0]         lim_wide;
  logic [LIM_W-1:0]    lim;
  logic [CAND_W-1:0]   lim_c;
  logic [ADDR_W-1:0]   lim_byte;
  logic [CAND_W-1:0]   cand_start;
  logic [BYTE_W-1:0]   scan_hi;
  logic [BYTE_W-1:0]   scan_bits;
  logic                scan_hit;
  logic [LIM_W-1:0]    scan_prime;
  logic [CAND_W-1:0]   scan_double;
  logic [BYTE_W-1:0]   clr_cur;
  logic [BYTE_W-1:0]   clr_wdata;

  pse_flag_ram #(
    .DEPTH (FLAG_BYTES),
    .WIDTH (BYTE_W)
  ) u_flag_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  // Clip the configured limit to what the store can hold.
  assign lim_wide = (32'(upper_limit_r) > 32'(MAX_LIMIT)) ? 32'(MAX_LIMIT)
                                                          : 32'(upper_limit_r);
  assign lim      = lim_wide[LIM_W-1:0];
  assign lim_c    = CAND_W'(lim);
  assign lim_byte = ADDR_W'(lim >> 3);

  // Never start below two.
  assign cand_start = (cand_r < FIRST_CAND) ? FIRST_CAND : cand_r;

  // Scan: drop flags below the candidate and above the limit, take the lowest.
  assign scan_hi     = (scan_addr_r == lim_byte) ? hi_mask(lim[2:0]) : FLAGS_ALL;
  assign scan_bits   = ram_rd & lo_mask(scan_lo_r) & scan_hi;
  assign scan_hit    = |scan_bits;
  assign scan_prime  = LIM_W'({scan_addr_r, low_bit(scan_bits)});
  assign scan_double = CAND_W'({scan_prime, 1'b0});

  // Clear: take the freshest copy of the byte, drop one flag.
  assign clr_cur   = (fwd_v_r && (fwd_addr_r == clr_addr_r)) ? fwd_data_r : ram_rd;
  assign clr_wdata = clr_cur & ~(FLAG_ONE << clr_bit_r);

  // Write port: fill sweep or the clear pipeline, never both.
  always_comb begin
    if (state_r == ST_FILL) begin
      ram_we = 1'b1;
      ram_wa = fill_addr_r;
      ram_wd = FLAGS_ALL;
    end else begin
      ram_we = clr_v_r;
      ram_wa = clr_addr_r;
      ram_wd = clr_wdata;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cand_nxt        = cand_r;
    upper_limit_nxt = cfg_we ? cfg_upper_limit : upper_limit_r;
    fill_addr_nxt   = fill_addr_r;
    fill_item_nxt   = fill_item_r;
    scan_addr_nxt   = scan_addr_r;
    scan_lo_nxt     = scan_lo_r;
    prime_nxt       = prime_r;
    mult_nxt        = mult_r;
    clr_v_nxt       = 1'b0;
    clr_addr_nxt    = clr_addr_r;
    clr_bit_nxt     = clr_bit_r;
    fwd_v_nxt       = clr_v_r;
    fwd_addr_nxt    = clr_addr_r;
    fwd_data_nxt    = clr_wdata;
    out_valid_nxt   = 1'b0;
    out_prime_nxt   = out_prime_r;
    out_found_nxt   = 1'b0;
    ram_re          = 1'b0;
    ram_ra          = scan_addr_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_restart) begin
            fill_addr_nxt = '0;
            fill_item_nxt = 1'b1;
            state_nxt     = ST_FILL;
          end else begin
            state_nxt = ST_PREP;
          end
        end
      end

      ST_FILL: begin
        fill_addr_nxt = fill_addr_r + 1'b1;
        if (fill_addr_r == LAST_ADDR) begin
          cand_nxt      = FIRST_CAND;
          fill_item_nxt = 1'b0;
          state_nxt     = fill_item_r ? ST_PREP : ST_IDLE;
        end
      end

      ST_PREP: begin
        if (cand_start > lim_c) begin
          // nothing left at or below the limit
          out_valid_nxt = 1'b1;
          out_prime_nxt = '0;
          cand_nxt      = lim_c + 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          ram_re        = 1'b1;
          ram_ra        = ADDR_W'(cand_start >> 3);
          scan_addr_nxt = ADDR_W'(cand_start >> 3);
          scan_lo_nxt   = cand_start[2:0];
          state_nxt     = ST_CHK;
        end
      end

      ST_CHK: begin
        if (scan_hit) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_prime_nxt = OUT_W'(scan_prime);
          cand_nxt      = CAND_W'(scan_prime) + 1'b1;
          prime_nxt     = scan_prime;
          mult_nxt      = scan_double;
          state_nxt     = (scan_double <= lim_c) ? ST_CLR : ST_IDLE;
        end else if (scan_addr_r < lim_byte) begin
          // advance to the next byte, reading it this cycle
          ram_re        = 1'b1;
          ram_ra        = scan_addr_r + 1'b1;
          scan_addr_nxt = scan_addr_r + 1'b1;
          scan_lo_nxt   = 3'd0;
        end else begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = '0;
          cand_nxt      = lim_c + 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_CLR: begin
        if (mult_r <= lim_c) begin
          ram_re       = 1'b1;
          ram_ra       = ADDR_W'(mult_r >> 3);
          clr_v_nxt    = 1'b1;
          clr_addr_nxt = ADDR_W'(mult_r >> 3);
          clr_bit_nxt  = mult_r[2:0];
          mult_nxt     = mult_r + CAND_W'(prime_r);
        end else begin
          // the last write lands this cycle
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_FILL;
      cand_r        <= FIRST_CAND;
      upper_limit_r <= CFG_W'(65535);
      fill_addr_r   <= '0;
      fill_item_r   <= 1'b0;
      clr_v_r       <= 1'b0;
      fwd_v_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      out_found_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cand_r        <= cand_nxt;
      upper_limit_r <= upper_limit_nxt;
      fill_addr_r   <= fill_addr_nxt;
      fill_item_r   <= fill_item_nxt;
      clr_v_r       <= clr_v_nxt;
      fwd_v_r       <= fwd_v_nxt;
      out_valid_r   <= out_valid_nxt;
      out_found_r   <= out_found_nxt;
    end
    scan_addr_r  <= scan_addr_nxt;
    scan_lo_r    <= scan_lo_nxt;
    prime_r      <= prime_nxt;
    mult_r       <= mult_nxt;
    clr_addr_r   <= clr_addr_nxt;
    clr_bit_r    <= clr_bit_nxt;
    fwd_addr_r   <= fwd_addr_nxt;
    fwd_data_r   <= fwd_data_nxt;
    out_prime_r  <= out_prime_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_prime_value = out_prime_r;
  assign out_found       = out_found_r;

`ifndef ASSERT_OFF
  // Result strobes never come in consecutive cycles.
  a_no_double_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result strobes in consecutive cycles");

  // The clear pipeline is drained before a new item can be taken.
  a_clear_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !clr_v_r)
    else $error("clear write still in flight while idle");

  // A reported prime is never below two.
  a_prime_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_prime_value >= OUT_W'(2)))
    else $error("reported prime below two");

  // Fill and clear never compete for the write port.
  a_fill_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> !clr_v_r)
    else $error("clear write during fill sweep");
`endif

endmodule
